@@ rtl/core/timer_queue_scheduler_defines.svh @@
// Assertion macros shared by the checker.
`ifndef TIMER_QUEUE_SCHEDULER_DEFINES_SVH
`define TIMER_QUEUE_SCHEDULER_DEFINES_SVH
`define TQS_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("%m: label failed");
`define TQS_ASSERT_NXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("%m: label failed");
`endif

@@ rtl/core/tqs_pkg.sv @@
`default_nettype none
package tqs_pkg;
    localparam int CAPACITY_DEF = 16;
    localparam int MAX_RESULTS  = 16;

    typedef enum logic [1:0] {
        OP_ONCE   = 2'd0,
        OP_REPEAT = 2'd1,
        OP_CANCEL = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        K_SCHEDULED  = 3'd0,
        K_FULL       = 3'd1,
        K_CANCEL_OK  = 3'd2,
        K_CANCEL_BAD = 3'd3,
        K_FIRED      = 3'd4,
        K_IDLE       = 3'd5
    } kind_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] delay_ms;
        logic [31:0] handle_in;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] handle_out;
        logic        is_repeat;
        logic        last;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_POP  = 2'd2,
        ST_DONE = 2'd3
    } st_t;
endpackage
`default_nettype wire

@@ rtl/core/tqs_front.sv @@
`default_nettype none
// Accept requests into a small queue for the engine.
module tqs_front (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire tqs_pkg::req_t s_data,
    output logic             q_valid,
    input  wire logic        q_pop,
    output tqs_pkg::req_t    q_data
);
    tqs_pkg::req_t buf_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, wr_reg;
    logic       push;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = buf_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wr_reg <= ~wr_reg;
            if (q_pop && q_valid) rd_reg <= ~rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) buf_reg[wr_reg] <= s_data;
    end
endmodule
`default_nettype wire

@@ rtl/core/tqs_engine.sv @@
`default_nettype none
// Carry out one request at a time over the slot array.
module tqs_engine #(
    parameter int CAPACITY = tqs_pkg::CAPACITY_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    output logic               q_pop,
    input  wire tqs_pkg::req_t q_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output tqs_pkg::rsp_t      m_data
);
    localparam int IW = $clog2(CAPACITY);
    localparam int RW = $clog2(tqs_pkg::MAX_RESULTS + 1);

    logic [CAPACITY-1:0] valid_reg, canc_reg, done_reg;
    logic [31:0] hnd_reg  [CAPACITY];
    logic [63:0] fire_reg [CAPACITY];
    logic [31:0] intv_reg [CAPACITY];
    logic [63:0] now_reg;
    logic [31:0] nexth_reg;

    tqs_pkg::st_t  st_reg, st_next;
    tqs_pkg::req_t cur_reg;
    logic [IW-1:0] idx_reg;
    logic          found_reg;
    logic [IW-1:0] best_reg;
    logic [RW-1:0] n_reg;
    tqs_pkg::rsp_t out_reg, out_next;
    logic          ov_reg;
    tqs_pkg::rsp_t pend_reg;
    logic          pv_reg;

    logic          cand, better, scan_end, room, live, cap_hit;
    logic          pop_go, done_go, emit;
    tqs_pkg::rsp_t fired;

    assign scan_end = (idx_reg == IW'(CAPACITY - 1));
    assign room     = !ov_reg || m_ready;
    assign live     = found_reg && !canc_reg[best_reg];
    assign cap_hit  = (n_reg == RW'(tqs_pkg::MAX_RESULTS - 1));
    assign m_valid  = ov_reg;
    assign m_data   = out_reg;
    assign q_pop    = (st_reg == tqs_pkg::ST_IDLE) && q_valid;

    // one slot per cycle: compare against the best so far
    always_comb begin
        cand   = valid_reg[idx_reg] && !done_reg[idx_reg] && (fire_reg[idx_reg] <= now_reg);
        better = !found_reg || (fire_reg[idx_reg] < fire_reg[best_reg]) ||
                 ((fire_reg[idx_reg] == fire_reg[best_reg]) &&
                  (hnd_reg[idx_reg] < hnd_reg[best_reg]));
    end

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            tqs_pkg::ST_IDLE: if (q_valid) st_next = tqs_pkg::ST_SCAN;
            tqs_pkg::ST_SCAN: if (scan_end) begin
                if (cur_reg.op == tqs_pkg::OP_TICK) st_next = tqs_pkg::ST_POP;
                else st_next = tqs_pkg::ST_DONE;
            end
            tqs_pkg::ST_POP: begin
                if (!found_reg) st_next = tqs_pkg::ST_DONE;
                else if (!live) st_next = tqs_pkg::ST_SCAN;
                else if (!pv_reg || room)
                    st_next = cap_hit ? tqs_pkg::ST_DONE : tqs_pkg::ST_SCAN;
            end
            tqs_pkg::ST_DONE: if (room) st_next = tqs_pkg::ST_IDLE;
        endcase
    end

    // a fired result waits in pend_reg until the next pop tells whether it is last
    always_comb begin
        pop_go  = (st_reg == tqs_pkg::ST_POP) && live && (!pv_reg || room);
        done_go = (st_reg == tqs_pkg::ST_DONE) && room;
        emit    = done_go || (pop_go && pv_reg);

        fired.kind       = tqs_pkg::K_FIRED;
        fired.handle_out = hnd_reg[best_reg];
        fired.is_repeat  = (intv_reg[best_reg] != 32'd0);
        fired.last       = 1'b0;

        out_next      = pend_reg;
        out_next.last = done_go;
        if (done_go) begin
            unique case (cur_reg.op)
                tqs_pkg::OP_ONCE, tqs_pkg::OP_REPEAT: begin
                    out_next.kind       = found_reg ? tqs_pkg::K_SCHEDULED : tqs_pkg::K_FULL;
                    out_next.handle_out = found_reg ? nexth_reg : 32'd0;
                    out_next.is_repeat  = 1'b0;
                end
                tqs_pkg::OP_CANCEL: begin
                    out_next.kind       = (cur_reg.handle_in == 32'd0) ?
                                          tqs_pkg::K_CANCEL_BAD : tqs_pkg::K_CANCEL_OK;
                    out_next.handle_out = cur_reg.handle_in;
                    out_next.is_repeat  = 1'b0;
                end
                tqs_pkg::OP_TICK: if (!pv_reg) begin
                    out_next.kind       = tqs_pkg::K_IDLE;
                    out_next.handle_out = 32'd0;
                    out_next.is_repeat  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= tqs_pkg::ST_IDLE;
            valid_reg <= '0;
            canc_reg  <= '0;
            done_reg  <= '0;
            now_reg   <= 64'd0;
            nexth_reg <= 32'd1;
            ov_reg    <= 1'b0;
            out_reg   <= '0;
            pv_reg    <= 1'b0;
            pend_reg  <= '0;
            cur_reg   <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            best_reg  <= '0;
            n_reg     <= '0;
        end else begin
            st_reg <= st_next;
            ov_reg <= emit || (ov_reg && !m_ready);
            if (emit) out_reg <= out_next;
            unique case (st_reg)
                tqs_pkg::ST_IDLE: if (q_valid) begin
                    cur_reg   <= q_data;
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    done_reg  <= '0;
                    n_reg     <= '0;
                    if (q_data.op == tqs_pkg::OP_TICK) now_reg <= now_reg + 64'd1;
                end
                tqs_pkg::ST_SCAN: begin
                    idx_reg <= scan_end ? '0 : idx_reg + IW'(1);
                    unique case (cur_reg.op)
                        tqs_pkg::OP_TICK: if (cand && better) begin
                            found_reg <= 1'b1;
                            best_reg  <= idx_reg;
                        end
                        tqs_pkg::OP_CANCEL:
                            if (valid_reg[idx_reg] && hnd_reg[idx_reg] == cur_reg.handle_in &&
                                cur_reg.handle_in != 32'd0)
                                canc_reg[idx_reg] <= 1'b1;
                        tqs_pkg::OP_ONCE, tqs_pkg::OP_REPEAT:
                            if (!valid_reg[idx_reg] && !found_reg) begin
                                found_reg <= 1'b1;
                                best_reg  <= idx_reg;
                            end
                    endcase
                end
                tqs_pkg::ST_POP: if (found_reg) begin
                    if (canc_reg[best_reg]) begin
                        // drop a cancelled timer without a result
                        done_reg[best_reg]  <= 1'b1;
                        valid_reg[best_reg] <= 1'b0;
                        canc_reg[best_reg]  <= 1'b0;
                        found_reg           <= 1'b0;
                    end else if (pop_go) begin
                        done_reg[best_reg] <= 1'b1;
                        if (fired.is_repeat)
                            fire_reg[best_reg] <= now_reg + {32'd0, intv_reg[best_reg]};
                        else
                            valid_reg[best_reg] <= 1'b0;
                        pend_reg  <= fired;
                        pv_reg    <= 1'b1;
                        n_reg     <= n_reg + RW'(1);
                        found_reg <= 1'b0;
                    end
                end
                tqs_pkg::ST_DONE: if (room) begin
                    pv_reg <= 1'b0;
                    if ((cur_reg.op == tqs_pkg::OP_ONCE || cur_reg.op == tqs_pkg::OP_REPEAT) &&
                        found_reg) begin
                        valid_reg[best_reg] <= 1'b1;
                        canc_reg[best_reg]  <= 1'b0;
                        hnd_reg[best_reg]   <= nexth_reg;
                        fire_reg[best_reg]  <= now_reg + {32'd0, cur_reg.delay_ms};
                        intv_reg[best_reg]  <= (cur_reg.op == tqs_pkg::OP_REPEAT) ?
                                               cur_reg.delay_ms : 32'd0;
                        nexth_reg <= (nexth_reg == 32'hFFFF_FFFF) ? 32'd1 : nexth_reg + 32'd1;
                    end
                end
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/timer_queue_scheduler.sv @@
`default_nettype none
// timer_queue_scheduler keeps up to CAPACITY timers and a millisecond clock. Requests
// (schedule once, schedule repeat, cancel, tick) enter a two-entry queue and are carried
// out one at a time by the engine, which scans one slot per cycle. A schedule or cancel
// request is taken, then all CAPACITY slots are scanned, then its single result is
// written. A tick scans again after each due timer it pops (cancelled ones included),
// until none is due or MAX_RESULTS timers have fired. Each result waits in an output
// register until m_ready, and a held result stalls the engine before its next result.
// The last flag marks the final result of each request.
module timer_queue_scheduler #(
    parameter int CAPACITY = tqs_pkg::CAPACITY_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire tqs_pkg::req_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output tqs_pkg::rsp_t      m_data
);
    logic          q_valid, q_pop;
    tqs_pkg::req_t q_data;

    // Hold up to two requests while the engine is busy.
    tqs_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .q_valid, .q_pop, .q_data
    );

    // Scan the slots, advance time on a tick, pop due timers in order.
    tqs_engine #(.CAPACITY(CAPACITY)) u_engine (
        .aclk, .aresetn, .q_valid, .q_pop, .q_data,
        .m_valid, .m_ready, .m_data
    );
endmodule
`default_nettype wire

@@ rtl/core/tqs_checker.sv @@
`default_nettype none
`include "timer_queue_scheduler_defines.svh"
module tqs_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire tqs_pkg::rsp_t m_data
);
    `TQS_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `TQS_ASSERT_IMP(a_kind, aclk, aresetn, m_valid, m_data.kind <= tqs_pkg::K_IDLE)
    `TQS_ASSERT_IMP(a_rep, aclk, aresetn, m_valid && m_data.is_repeat,
        m_data.kind == tqs_pkg::K_FIRED)
endmodule
bind timer_queue_scheduler tqs_checker u_chk (.*);
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_REQUESTS = 370;

    logic            aclk;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    tqs_pkg::req_t   s_data;
    logic            m_valid;
    logic            m_ready;
    tqs_pkg::rsp_t   m_data;

    timer_queue_scheduler #(.CAPACITY(SLOTS)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Clock: 10 ns period.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Predicted timer store, mirrors the block's state.
    logic        tmr_valid    [SLOTS];
    logic [31:0] tmr_handle   [SLOTS];
    logic [63:0] tmr_due      [SLOTS];
    logic [31:0] tmr_interval [SLOTS];
    logic        tmr_cancel   [SLOTS];
    logic [63:0] now_ms;
    logic [31:0] handle_next;

    tqs_pkg::rsp_t pending_rsp[$];
    int   mismatches = 0;
    int   fired_seen = 0;
    int   full_seen = 0;
    int   idle_seen = 0;
    int   stall_cycles;

    function automatic tqs_pkg::rsp_t make_rsp(tqs_pkg::kind_t k, logic [31:0] h, logic rep);
        tqs_pkg::rsp_t r;
        r.kind = k;
        r.handle_out = h;
        r.is_repeat = rep;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic void timers_reset();
        for (int i = 0; i < SLOTS; i++) begin
            tmr_valid[i] = 1'b0;
            tmr_cancel[i] = 1'b0;
            tmr_handle[i] = '0;
            tmr_due[i] = '0;
            tmr_interval[i] = '0;
        end
        now_ms = '0;
        handle_next = 32'd1;
    endfunction

    // Apply one request to the predicted store and queue its responses.
    function automatic void predict_timer_request(tqs_pkg::req_t rq);
        tqs_pkg::rsp_t out[$];
        bit   popped[SLOTS];
        int   best;
        bit   placed;
        case (tqs_pkg::op_t'(rq.op))
            tqs_pkg::OP_ONCE, tqs_pkg::OP_REPEAT: begin
                placed = 0;
                for (int i = 0; i < SLOTS && !placed; i++) begin
                    if (!tmr_valid[i]) begin
                        placed = 1;
                        tmr_valid[i] = 1'b1;
                        tmr_cancel[i] = 1'b0;
                        tmr_handle[i] = handle_next;
                        tmr_due[i] = now_ms + {32'd0, rq.delay_ms};
                        tmr_interval[i] = (rq.op == tqs_pkg::OP_REPEAT) ? rq.delay_ms : 32'd0;
                        out.insert(out.size(), make_rsp(tqs_pkg::K_SCHEDULED, handle_next, 1'b0));
                        // Skip zero on wrap.
                        handle_next = (handle_next == 32'hFFFF_FFFF) ? 32'd1
                                                                     : handle_next + 1;
                    end
                end
                if (!placed) out.insert(out.size(), make_rsp(tqs_pkg::K_FULL, 32'd0, 1'b0));
            end
            tqs_pkg::OP_CANCEL: begin
                if (rq.handle_in == 32'd0) begin
                    out.insert(out.size(), make_rsp(tqs_pkg::K_CANCEL_BAD, 32'd0, 1'b0));
                end else begin
                    for (int i = 0; i < SLOTS; i++)
                        if (tmr_valid[i] && tmr_handle[i] == rq.handle_in)
                            tmr_cancel[i] = 1'b1;
                    out.insert(out.size(), make_rsp(tqs_pkg::K_CANCEL_OK, rq.handle_in, 1'b0));
                end
            end
            default: begin
                now_ms = now_ms + 64'd1;
                for (int i = 0; i < SLOTS; i++) popped[i] = 0;
                while (out.size() < tqs_pkg::MAX_RESULTS) begin
                    best = -1;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!tmr_valid[i] || popped[i] || tmr_due[i] > now_ms) continue;
                        if (best < 0 || tmr_due[i] < tmr_due[best] ||
                            (tmr_due[i] == tmr_due[best] &&
                             tmr_handle[i] < tmr_handle[best]))
                            best = i;
                    end
                    if (best < 0) break;
                    popped[best] = 1;
                    if (tmr_cancel[best]) begin
                        // Drop cancelled timers silently.
                        tmr_valid[best] = 1'b0;
                        tmr_cancel[best] = 1'b0;
                    end else if (tmr_interval[best] != 32'd0) begin
                        tmr_due[best] = now_ms + {32'd0, tmr_interval[best]};
                        out.insert(out.size(),
                                   make_rsp(tqs_pkg::K_FIRED, tmr_handle[best], 1'b1));
                    end else begin
                        tmr_valid[best] = 1'b0;
                        out.insert(out.size(),
                                   make_rsp(tqs_pkg::K_FIRED, tmr_handle[best], 1'b0));
                    end
                end
                if (out.size() == 0)
                    out.insert(out.size(), make_rsp(tqs_pkg::K_IDLE, 32'd0, 1'b0));
            end
        endcase
        out[out.size() - 1].last = 1'b1;
        foreach (out[i]) pending_rsp.insert(pending_rsp.size(), out[i]);
    endfunction

    // Directed requests; kind_fix and handle_fix apply only when typed_check is set and
    // check the predicted first response of the request against values read off directly.
    typedef struct {
        tqs_pkg::op_t   op;
        logic [31:0]    delay_ms;
        logic [31:0]    handle_in;
        bit             typed_check;
        tqs_pkg::kind_t kind_fix;
        logic [31:0]    handle_fix;
    } directed_row_t;

    directed_row_t directed_rows[$];

    function automatic void add_row(tqs_pkg::op_t op, logic [31:0] d, logic [31:0] h,
                                    bit tc = 0, tqs_pkg::kind_t k = tqs_pkg::K_IDLE,
                                    logic [31:0] hf = 0);
        directed_row_t r;
        r.op = op; r.delay_ms = d; r.handle_in = h;
        r.typed_check = tc; r.kind_fix = k; r.handle_fix = hf;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    // Response checker.
    tqs_pkg::rsp_t fixed_expect[$];
    int   fixed_at[$];
    int   rsp_count = 0;

    always @(posedge aclk) begin
        tqs_pkg::rsp_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response kind=%0d handle=%0h rep=%0b last=%0b",
                             m_data.kind, m_data.handle_out, m_data.is_repeat,
                             m_data.last);
            end else begin
                exp_r = pending_rsp.pop_front();
                if (fixed_at.size() > 0 && fixed_at[0] == rsp_count) begin
                    void'(fixed_at.pop_front());
                    if (fixed_expect[0].kind != exp_r.kind ||
                        fixed_expect[0].handle_out != exp_r.handle_out) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("table entry %0d: typed kind=%0d h=%0h", rsp_count,
                                     fixed_expect[0].kind, fixed_expect[0].handle_out);
                    end
                    void'(fixed_expect.pop_front());
                end
                if (m_data.kind != exp_r.kind || m_data.handle_out != exp_r.handle_out ||
                    m_data.is_repeat != exp_r.is_repeat || m_data.last != exp_r.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected kind=%0d h=%0h rep=%0b last=%0b,",
                                  " got kind=%0d h=%0h rep=%0b last=%0b"},
                                 exp_r.kind, exp_r.handle_out, exp_r.is_repeat,
                                 exp_r.last, m_data.kind, m_data.handle_out,
                                 m_data.is_repeat, m_data.last);
                end
                if (exp_r.kind == tqs_pkg::K_FIRED) fired_seen++;
                if (exp_r.kind == tqs_pkg::K_FULL) full_seen++;
                if (exp_r.kind == tqs_pkg::K_IDLE) idle_seen++;
            end
            rsp_count++;
        end
    end

    // Receiver: stall on its own pattern, with calm stretches.
    int rdy_phase;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rdy_phase <= 0;
        end else begin
            rdy_phase <= rdy_phase + 1;
            if ((rdy_phase / 300) % 3 == 2) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 9) > 2);
        end
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", stall_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Present one request and hold it until accepted, then predict it.
    task automatic send_request(tqs_pkg::req_t rq);
        s_valid <= 1'b1;
        s_data <= rq;
        do @(posedge aclk); while (!s_ready);
        predict_timer_request(rq);
    endtask

    // Sender bursts: occasionally insert a gap after a request.
    int burst_left;
    task automatic sender_gap();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    task automatic drain_responses();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_rsp.size() != 0);
    endtask

    function automatic logic [31:0] random_delay();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd0;
            default: return $urandom_range(0, 12);
        endcase
    endfunction

    // Pick a handle to cancel: mostly live ones, sometimes zero or random.
    function automatic logic [31:0] random_cancel_handle();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 32'd0;
        if (pick == 1) return $urandom();
        if (handle_next > 32'd20)
            return handle_next - $urandom_range(1, 20);
        return $urandom_range(1, 20);
    endfunction

    initial begin
        tqs_pkg::req_t rq;
        int            row_rsp_base;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        burst_left = 0;
        timers_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: reset state, extremes, each operation and corner.
        add_row(tqs_pkg::OP_TICK,   0, 0, 1, tqs_pkg::K_IDLE, 0);
        add_row(tqs_pkg::OP_CANCEL, 0, 0, 1, tqs_pkg::K_CANCEL_BAD, 0);
        add_row(tqs_pkg::OP_CANCEL, 0, 32'hFFFF_FFFF, 1, tqs_pkg::K_CANCEL_OK,
                32'hFFFF_FFFF);
        add_row(tqs_pkg::OP_ONCE,   0, 0, 1, tqs_pkg::K_SCHEDULED, 1);
        add_row(tqs_pkg::OP_REPEAT, 0, 0, 1, tqs_pkg::K_SCHEDULED, 2);
        add_row(tqs_pkg::OP_ONCE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, tqs_pkg::K_SCHEDULED, 3);
        add_row(tqs_pkg::OP_REPEAT, 2, 0);
        add_row(tqs_pkg::OP_ONCE,   1, 0);
        add_row(tqs_pkg::OP_CANCEL, 0, 8);
        add_row(tqs_pkg::OP_TICK,   0, 0);
        add_row(tqs_pkg::OP_TICK,   0, 0);
        add_row(tqs_pkg::OP_CANCEL, 0, 4);
        add_row(tqs_pkg::OP_TICK,   0, 0);
        add_row(tqs_pkg::OP_TICK,   0, 0);
        foreach (directed_rows[i]) begin
            rq.op = directed_rows[i].op;
            rq.delay_ms = directed_rows[i].delay_ms;
            rq.handle_in = directed_rows[i].handle_in;
            row_rsp_base = rsp_count + pending_rsp.size();
            if (directed_rows[i].typed_check) begin
                fixed_at.insert(fixed_at.size(), row_rsp_base);
                fixed_expect.insert(fixed_expect.size(),
                                    make_rsp(directed_rows[i].kind_fix,
                                             directed_rows[i].handle_fix, 1'b0));
            end
            send_request(rq);
            sender_gap();
        end

        // Fill the store: queue_full, then all newly scheduled timers due on one tick.
        drain_responses();
        for (int i = 0; i < 18; i++) begin
            rq.op = tqs_pkg::OP_REPEAT; rq.delay_ms = 32'd1; rq.handle_in = $urandom();
            send_request(rq);
        end
        rq.op = tqs_pkg::OP_TICK;
        send_request(rq);
        rq.op = tqs_pkg::OP_CANCEL;
        for (int i = 0; i < SLOTS; i++) begin
            rq.handle_in = handle_next - 1 - i;
            send_request(rq);
        end
        rq.op = tqs_pkg::OP_TICK;
        send_request(rq);

        // Hold off until every pending response has been delivered.
        drain_responses();

        // Random part: mostly schedules/ticks with short delays.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            case ($urandom_range(0, 9))
                0, 1:    rq.op = tqs_pkg::OP_ONCE;
                2, 3:    rq.op = tqs_pkg::OP_REPEAT;
                4:       rq.op = tqs_pkg::OP_CANCEL;
                default: rq.op = tqs_pkg::OP_TICK;
            endcase
            rq.delay_ms = random_delay();
            rq.handle_in = (rq.op == tqs_pkg::OP_CANCEL) ? random_cancel_handle() : $urandom();
            send_request(rq);
            sender_gap();
            if (n == RANDOM_REQUESTS / 2) drain_responses();
        end

        drain_responses();
        repeat (100) @(posedge aclk);
        $display("covered %0d responses: %0d fired, %0d store-full, %0d idle ticks",
                 rsp_count, fired_seen, full_seen, idle_seen);
        $display("table rows, a full store, cancels and random traffic under output stalls");
        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("mismatches: %0d, left pending: %0d", mismatches, pending_rsp.size());
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
